/* hw/rtl/ppmfrr_pkg.sv */
// Package for the PPM frame record/replay block.
// Holds the channel word and frame types, the switch and button bit positions
// and the per-channel clamp limits. Depends on nothing.
`default_nettype none

package ppmfrr_pkg;

	localparam int CHANNELS = 6;
	localparam int CH_W     = 18;
	localparam int POS_W    = 6;
	localparam int DEB_W    = 16;

	typedef logic [CH_W-1:0] ch_t;
	typedef ch_t [CHANNELS-1:0] frame_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [DEB_W-1:0] deb_t;

	// Bit positions in the switches field.
	localparam int SW_HW_RELAY = 0;
	localparam int SW_RECORD   = 1;
	localparam int SW_REPLAY   = 2;
	localparam int SW_FILTER   = 3;

	// Bit positions in the buttons field.
	localparam int BTN_STORE  = 0;
	localparam int BTN_REWIND = 1;
	localparam int BTN_EMIT   = 2;
	localparam int BTN_BACK   = 3;

	localparam deb_t DEBOUNCE_RESET = 16'd8;

	localparam ch_t CH_MIN [CHANNELS] = '{
		18'd68000, 18'd70000, 18'd70000, 18'd67000, 18'd60000, 18'd60000
	};
	localparam ch_t CH_MAX [CHANNELS] = '{
		18'd151700, 18'd151200, 18'd152300, 18'd159000, 18'd162500, 18'd162500
	};

endpackage

`default_nettype wire

/* hw/rtl/ppmfrr_if.sv */
// Handshake interfaces for the PPM frame record/replay block: the frame input
// channel and the result channel, each with valid, ready and payload.
// Depends on ppmfrr_pkg.
`default_nettype none

interface ppmfrr_in_if;
	logic              valid;
	logic              ready;
	ppmfrr_pkg::ch_t   in_ch1;
	ppmfrr_pkg::ch_t   in_ch2;
	ppmfrr_pkg::ch_t   in_ch3;
	ppmfrr_pkg::ch_t   in_ch4;
	ppmfrr_pkg::ch_t   in_ch5;
	ppmfrr_pkg::ch_t   in_ch6;
	logic [3:0]        switches;
	logic [3:0]        buttons;

	modport source (output valid, output in_ch1, output in_ch2, output in_ch3,
		output in_ch4, output in_ch5, output in_ch6, output switches,
		output buttons, input ready);
	modport sink (input valid, input in_ch1, input in_ch2, input in_ch3,
		input in_ch4, input in_ch5, input in_ch6, input switches,
		input buttons, output ready);
endinterface

interface ppmfrr_out_if;
	logic              valid;
	logic              ready;
	logic              software_relay;
	ppmfrr_pkg::ch_t   out_ch1;
	ppmfrr_pkg::ch_t   out_ch2;
	ppmfrr_pkg::ch_t   out_ch3;
	ppmfrr_pkg::ch_t   out_ch4;
	ppmfrr_pkg::ch_t   out_ch5;
	ppmfrr_pkg::ch_t   out_ch6;
	ppmfrr_pkg::pos_t  record_position;
	ppmfrr_pkg::pos_t  replay_position;

	modport source (output valid, output software_relay, output out_ch1,
		output out_ch2, output out_ch3, output out_ch4, output out_ch5,
		output out_ch6, output record_position, output replay_position,
		input ready);
	modport sink (input valid, input software_relay, input out_ch1,
		input out_ch2, input out_ch3, input out_ch4, input out_ch5,
		input out_ch6, input record_position, input replay_position,
		output ready);
endinterface

`default_nettype wire

/* hw/rtl/ppmfrr_clamp.sv */
// Per-channel pulse width limiter for the PPM frame record/replay block.
// Depends on ppmfrr_pkg for the frame type and the fixed limits.
`default_nettype none

module ppmfrr_clamp (
	input  wire logic               en,
	input  wire ppmfrr_pkg::frame_t frame_in,
	output ppmfrr_pkg::frame_t      frame_out
);
	import ppmfrr_pkg::*;

	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			frame_out[c] = frame_in[c];
			if (en) begin
				if (frame_in[c] < CH_MIN[c]) begin
					frame_out[c] = CH_MIN[c];
				end else if (frame_in[c] > CH_MAX[c]) begin
					frame_out[c] = CH_MAX[c];
				end
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/ppmfrr_frame_mem.sv */
// Frame store: one row per recorded frame, all six channels side by side.
// One write port and one read port, read data registered. Depends on ppmfrr_pkg.
`default_nettype none

module ppmfrr_frame_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic               clk,
	input  wire logic               we,
	input  wire logic [AW-1:0]      waddr,
	input  wire ppmfrr_pkg::frame_t wdata,
	input  wire logic               re,
	input  wire logic [AW-1:0]      raddr,
	output ppmfrr_pkg::frame_t      rdata
);
	import ppmfrr_pkg::*;

	frame_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/ppm_frame_record_replay_top.sv */
// Top level of the PPM frame record/replay block.
// Depends on ppmfrr_pkg, ppmfrr_if, ppmfrr_clamp and ppmfrr_frame_mem.
//
// Usage. Each transaction on in_frame carries one received six-channel PPM
// frame together with the switch and button states seen with it. For every
// accepted frame exactly one transaction leaves on out_frame: the relay flag,
// the six held output widths and the record and replay positions after that
// frame. The user writes the debounce threshold through cfg_we / cfg_wdata only
// while the block is idle, which the block does not enforce; it resets to 8.
//
// Pipeline. An accepted frame moves into the read stage while the store is
// read, then into the output register, where it waits until it is taken.
// One frame can be accepted every cycle while the output is not stalled and
// the clearing pass is over: each frame needs at most one row write and one
// row read, and the store has a write port and a read port.
//
// Reset. After arst_n is released the block zeroes the frame store, one row a
// cycle, from row 0 to the last row; in_frame.ready stays low during that pass.
//
// Stalls. When out_frame.ready is low the output register holds its result;
// one more frame may then sit in the read stage, after which in_frame.ready
// drops until the receiver takes the waiting result.
`default_nettype none

module ppm_frame_record_replay_top #(
	parameter int FRAME_DEPTH = 64
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	ppmfrr_in_if.sink                   in_frame,
	ppmfrr_out_if.source                out_frame,
	input  wire logic                   cfg_we,
	input  wire ppmfrr_pkg::deb_t       cfg_wdata
);
	import ppmfrr_pkg::*;

	localparam int AW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
	localparam logic [AW-1:0] LAST_ROW = AW'(FRAME_DEPTH - 1);

	typedef logic [AW-1:0] idx_t;

	// Control state.
	deb_t  deb_q;
	idx_t  rec_idx_q;
	idx_t  rep_idx_q;
	deb_t  press_cnt_q;
	logic  press_fired_q;
	logic  clr_busy_q;
	idx_t  clr_row_q;

	// Read stage.
	logic   s1_valid_q;
	frame_t frame_s1;
	logic   relay_s1;
	logic   fire_s1;
	logic   fwd_s1;
	frame_t fwd_data_s1;
	pos_t   rec_pos_s1;
	pos_t   rep_pos_s1;

	// Held outputs and the output register.
	frame_t held_q;
	logic   out_valid_q;
	logic   out_relay_q;
	frame_t out_frame_q;
	pos_t   out_rec_pos_q;
	pos_t   out_rep_pos_q;

	frame_t raw_frame;
	frame_t clamped;
	frame_t rd_row;
	logic   out_free;
	logic   s1_adv;
	logic   acc;
	logic   rec_mode;
	logic   rep_mode;
	logic   do_store;
	logic   do_rewind;
	logic   emit_held;
	logic   fire;
	idx_t   rec_idx_d;
	idx_t   rep_idx_d;
	idx_t   rep_after_emit;
	deb_t   press_cnt_d;
	logic   press_fired_d;
	logic   mem_we;
	idx_t   mem_waddr;
	frame_t mem_wdata;
	frame_t held_d;

	assign raw_frame = {in_frame.in_ch6, in_frame.in_ch5, in_frame.in_ch4,
		in_frame.in_ch3, in_frame.in_ch2, in_frame.in_ch1};

	ppmfrr_clamp u_clamp (
		.en        (in_frame.switches[SW_FILTER]),
		.frame_in  (raw_frame),
		.frame_out (clamped)
	);

	// Handshake: the read stage moves on whenever the output register is
	// free or being emptied, and a new frame enters whenever the read stage
	// will be free and the clearing pass is over.
	assign out_free = !out_valid_q || out_frame.ready;
	assign s1_adv   = s1_valid_q && out_free;
	assign in_frame.ready = !clr_busy_q && (!s1_valid_q || out_free);
	assign acc = in_frame.valid && in_frame.ready;

	assign rec_mode  = in_frame.switches[SW_RECORD];
	assign rep_mode  = in_frame.switches[SW_REPLAY];
	assign do_store  = rec_mode && in_frame.buttons[BTN_STORE];
	assign do_rewind = rec_mode && !in_frame.buttons[BTN_STORE] &&
		in_frame.buttons[BTN_REWIND];
	assign emit_held = rep_mode && in_frame.buttons[BTN_EMIT];

	// Index and debounce updates are all decided in the accept cycle, so the
	// next frame sees them at once.
	always_comb begin
		rec_idx_d = rec_idx_q;
		if (do_store) begin
			if (rec_idx_q != LAST_ROW) begin
				rec_idx_d = rec_idx_q + 1'b1;
			end
		end else if (do_rewind) begin
			if (rec_idx_q != '0) begin
				rec_idx_d = rec_idx_q - 1'b1;
			end
		end

		fire          = 1'b0;
		press_cnt_d   = '0;
		press_fired_d = 1'b0;
		if (emit_held) begin
			press_cnt_d   = press_cnt_q;
			press_fired_d = press_fired_q;
			if (press_cnt_q < deb_q) begin
				press_cnt_d   = press_cnt_q + 1'b1;
				press_fired_d = 1'b0;
			end else if (!press_fired_q) begin
				fire          = 1'b1;
				press_fired_d = 1'b1;
			end
		end

		rep_after_emit = rep_idx_q;
		if (fire && rep_idx_q != LAST_ROW) begin
			rep_after_emit = rep_idx_q + 1'b1;
		end
		rep_idx_d = rep_after_emit;
		if (rep_mode && in_frame.buttons[BTN_BACK] && rep_after_emit != '0) begin
			rep_idx_d = rep_after_emit - 1'b1;
		end
	end

	// The write port serves the clearing pass first, then record stores and
	// rewinds.
	always_comb begin
		if (clr_busy_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_row_q;
			mem_wdata = '0;
		end else begin
			mem_we    = acc && (do_store || do_rewind);
			mem_waddr = rec_idx_q;
			mem_wdata = do_store ? clamped : '0;
		end
	end

	ppmfrr_frame_mem #(
		.DEPTH (FRAME_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (acc && fire),
		.raddr (rep_idx_q),
		.rdata (rd_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_q         <= DEBOUNCE_RESET;
			rec_idx_q     <= '0;
			rep_idx_q     <= '0;
			press_cnt_q   <= '0;
			press_fired_q <= 1'b0;
			clr_busy_q    <= 1'b1;
			clr_row_q     <= '0;
			s1_valid_q    <= 1'b0;
			out_valid_q   <= 1'b0;
			held_q        <= '0;
		end else begin
			if (cfg_we) begin
				deb_q <= cfg_wdata;
			end
			if (clr_busy_q) begin
				clr_row_q <= clr_row_q + 1'b1;
				if (clr_row_q == LAST_ROW) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (acc) begin
				rec_idx_q     <= rec_idx_d;
				rep_idx_q     <= rep_idx_d;
				press_cnt_q   <= press_cnt_d;
				press_fired_q <= press_fired_d;
			end
			if (acc) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
				held_q      <= held_d;
			end else if (out_frame.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Read stage payload. A replay read of the row being written in the same
	// cycle takes the freshly written data instead of the stale array word.
	always_ff @(posedge clk) begin
		if (acc) begin
			frame_s1    <= clamped;
			relay_s1    <= !in_frame.switches[SW_HW_RELAY];
			fire_s1     <= fire;
			fwd_s1      <= mem_we && (rec_idx_q == rep_idx_q);
			fwd_data_s1 <= mem_wdata;
			rec_pos_s1  <= POS_W'(rec_idx_d);
			rep_pos_s1  <= POS_W'(rep_idx_d);
		end
	end

	always_comb begin
		held_d = held_q;
		if (fire_s1) begin
			held_d = fwd_s1 ? fwd_data_s1 : rd_row;
		end else if (relay_s1) begin
			held_d = frame_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_relay_q   <= relay_s1;
			out_frame_q   <= held_d;
			out_rec_pos_q <= rec_pos_s1;
			out_rep_pos_q <= rep_pos_s1;
		end
	end

	assign out_frame.valid           = out_valid_q;
	assign out_frame.software_relay  = out_relay_q;
	assign out_frame.out_ch1         = out_frame_q[0];
	assign out_frame.out_ch2         = out_frame_q[1];
	assign out_frame.out_ch3         = out_frame_q[2];
	assign out_frame.out_ch4         = out_frame_q[3];
	assign out_frame.out_ch5         = out_frame_q[4];
	assign out_frame.out_ch6         = out_frame_q[5];
	assign out_frame.record_position = out_rec_pos_q;
	assign out_frame.replay_position = out_rep_pos_q;

endmodule

`default_nettype wire
